/* sv/sru_pkg.sv */
package sru_pkg;

    // x store geometry
    localparam int MAX_SIZE = 64;
    localparam int VEC_AW   = $clog2(MAX_SIZE);

    // field widths
    localparam int IDX_W   = 6;
    localparam int N_W     = 7;
    localparam int X_W     = 16;
    localparam int A_W     = 32;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 3;
    localparam int WORD_W  = 2 * X_W;

    // datapath widths
    localparam int PROD_W     = 2 * X_W;
    localparam int PSUM_W     = PROD_W + 1;
    localparam int APROD_W    = X_W + PSUM_W;
    localparam int ASUM_W     = APROD_W + 1;
    localparam int FRAC_SHIFT = 27;
    localparam int RND_W      = ASUM_W - FRAC_SHIFT;
    localparam logic signed [ASUM_W-1:0] RND_HALF = ASUM_W'(1) <<< (FRAC_SHIFT - 1);

    // command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_N          = 3'd0;
    localparam logic [CIDX_W-1:0] REG_ALPHA_RE   = 3'd1;
    localparam logic [CIDX_W-1:0] REG_ALPHA_IM   = 3'd2;
    localparam logic [CIDX_W-1:0] REG_HERMITIAN  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_ACCUMULATE = 3'd4;
    localparam logic [CIDX_W-1:0] REG_CONJ_X     = 3'd5;

    typedef struct packed {
        logic                    command;
        logic [IDX_W-1:0]        vec_index;
        logic signed [X_W-1:0]   x_real;
        logic signed [X_W-1:0]   x_imag;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [A_W-1:0]   a_real;
        logic signed [A_W-1:0]   a_imag;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [A_W-1:0]   new_real;
        logic signed [A_W-1:0]   new_imag;
        logic [1:0]              status;
    } rsp_t;

    // arithmetic controls, static while requests are in flight
    typedef struct packed {
        logic signed [X_W-1:0]   alpha_re;
        logic signed [X_W-1:0]   alpha_im;
        logic                    hermitian;
        logic                    conj_x;
    } cfg_t;

    // sideband that travels with an update through the pipeline
    typedef struct packed {
        logic                    valid;
        logic                    err;
        logic                    diag;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [A_W-1:0]   a_real;
        logic signed [A_W-1:0]   a_imag;
    } tag_t;

endpackage

/* sv/sru_vec_mem.sv */
module sru_vec_mem (
    input  logic                          clk,
    input  logic                          we,
    input  logic [sru_pkg::VEC_AW-1:0]    waddr,
    input  logic [sru_pkg::WORD_W-1:0]    wdata,
    input  logic                          re,
    input  logic [sru_pkg::VEC_AW-1:0]    raddr_a,
    input  logic [sru_pkg::VEC_AW-1:0]    raddr_b,
    output logic [sru_pkg::WORD_W-1:0]    rdata_a,
    output logic [sru_pkg::WORD_W-1:0]    rdata_b
);
    import sru_pkg::*;

    logic [WORD_W-1:0] mem [MAX_SIZE];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* sv/sru_arith.sv */
module sru_arith (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  sru_pkg::cfg_t                       cfg,
    input  sru_pkg::tag_t                       tag_in,
    input  logic [sru_pkg::WORD_W-1:0]          xi_word,
    input  logic [sru_pkg::WORD_W-1:0]          xj_word,
    output sru_pkg::tag_t                       tag_out,
    output logic signed [sru_pkg::RND_W-1:0]    tr,
    output logic signed [sru_pkg::RND_W-1:0]    ti
);
    import sru_pkg::*;

    logic signed [X_W-1:0]     xr_i, xim_i, xr_j, xim_j;
    logic                      neg_i, neg_j, neg_ii;
    logic signed [X_W-1:0]     al_i;

    tag_t                      tag2_reg, tag3_reg, tag4_reg, tag5_reg;
    logic signed [PROD_W-1:0]  rr_reg, ii_reg, ri_reg, ir_reg;
    logic signed [PSUM_W-1:0]  pr_next, pi_next, pr_reg, pi_reg;
    logic signed [PSUM_W-1:0]  ri_ext, ir_ext;
    logic signed [APROD_W-1:0] arr_reg, aii_reg, ari_reg, air_reg;
    logic signed [ASUM_W-1:0]  sr_next, si_next;
    logic signed [RND_W-1:0]   tr_reg, ti_reg;

    assign xr_i  = xi_word[WORD_W-1:X_W];
    assign xim_i = xi_word[X_W-1:0];
    assign xr_j  = xj_word[WORD_W-1:X_W];
    assign xim_j = xj_word[X_W-1:0];

    // sign of each imaginary part after conjugation
    assign neg_i  = cfg.conj_x;
    assign neg_j  = cfg.conj_x ^ cfg.hermitian;
    assign neg_ii = neg_i ^ neg_j;
    assign al_i   = cfg.hermitian ? '0 : cfg.alpha_im;

    always_comb
    begin
        ri_ext  = PSUM_W'(ri_reg);
        ir_ext  = PSUM_W'(ir_reg);
        pr_next = neg_ii ? PSUM_W'(rr_reg) + PSUM_W'(ii_reg)
                         : PSUM_W'(rr_reg) - PSUM_W'(ii_reg);
        pi_next = (neg_j ? -ri_ext : ri_ext) + (neg_i ? -ir_ext : ir_ext);
        sr_next = ASUM_W'(arr_reg) - ASUM_W'(aii_reg) + RND_HALF;
        si_next = ASUM_W'(ari_reg) + ASUM_W'(air_reg) + RND_HALF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
            tag5_reg <= '0;
        end
        else if (adv)
        begin
            tag2_reg <= tag_in;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
            tag5_reg <= tag4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // raw x products
            rr_reg  <= xr_i * xr_j;
            ii_reg  <= xim_i * xim_j;
            ri_reg  <= xr_i * xim_j;
            ir_reg  <= xim_i * xr_j;
            // complex product, Q3.30
            pr_reg  <= pr_next;
            pi_reg  <= pi_next;
            // alpha products
            arr_reg <= cfg.alpha_re * pr_reg;
            aii_reg <= al_i * pi_reg;
            ari_reg <= cfg.alpha_re * pi_reg;
            air_reg <= al_i * pr_reg;
            // round half up to Q8.15
            tr_reg  <= sr_next[ASUM_W-1:FRAC_SHIFT];
            ti_reg  <= si_next[ASUM_W-1:FRAC_SHIFT];
        end
    end

    assign tag_out = tag5_reg;
    assign tr      = tr_reg;
    assign ti      = ti_reg;

endmodule

/* sv/symmetric_rank1_update.sv */
// Lower-triangle rank-1 update A += alpha*x*x^T (or alpha*x*x^H) on complex
// fixed point. Load requests (command 0) write x(vec_index) into a 64-entry
// store and give no response; update requests (command 1) carry the old
// A(row,col) and give one response with the new element (A plus the alpha term,
// or the alpha term alone when accumulate is off). One request is taken
// every cycle; the only throttle is the output register: req_stall is high
// exactly when a response is held there under rsp_stall. The x store is a
// memory with two registered read ports (x(row) and x(col) are read in the
// same cycle) and one write port, and it has no reset: update only elements
// whose x entries were loaded. A load is visible to the very next request.
// Configuration is written through cfg_we/cfg_index/cfg_wdata and must only
// change while no request is in flight.
module symmetric_rank1_update (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sru_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [sru_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  sru_pkg::req_t                 req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output sru_pkg::rsp_t                 rsp
);
    import sru_pkg::*;

    // configuration registers
    logic [N_W-1:0]          n_reg;
    logic signed [X_W-1:0]   alpha_re_reg;
    logic signed [X_W-1:0]   alpha_im_reg;
    logic                    herm_reg;
    logic                    accum_reg;
    logic                    conj_reg;

    // pipeline control
    logic                    adv;
    logic                    accept;
    logic                    mem_we;
    logic                    bad_idx;
    cfg_t                    cfg;
    tag_t                    tag1_next, tag1_reg, tag5;
    logic [WORD_W-1:0]       xi_word, xj_word;
    logic signed [RND_W-1:0] tr, ti;

    // final stage
    logic signed [A_W:0]     sum_re, sum_im;
    logic                    sat_re, sat_im;
    logic signed [A_W-1:0]   val_re, val_im;
    rsp_t                    rsp_next, rsp_reg;
    logic                    rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg        <= N_W'(MAX_SIZE > 64 ? 64 : MAX_SIZE);
            alpha_re_reg <= X_W'(4096);
            alpha_im_reg <= '0;
            herm_reg     <= 1'b0;
            accum_reg    <= 1'b1;
            conj_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_N:          n_reg        <= cfg_wdata[N_W-1:0];
                REG_ALPHA_RE:   alpha_re_reg <= cfg_wdata;
                REG_ALPHA_IM:   alpha_im_reg <= cfg_wdata;
                REG_HERMITIAN:  herm_reg     <= cfg_wdata[0];
                REG_ACCUMULATE: accum_reg    <= cfg_wdata[0];
                REG_CONJ_X:     conj_reg     <= cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    assign cfg.alpha_re  = alpha_re_reg;
    assign cfg.alpha_im  = alpha_im_reg;
    assign cfg.hermitian = herm_reg;
    assign cfg.conj_x    = conj_reg;

    // whole pipeline moves unless a response sits stalled in the output register
    assign adv       = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !adv;
    assign accept    = req_valid && adv;

    // loads write at acceptance; any later read sees it, so no bypass needed
    assign mem_we = accept && (req.command == CMD_LOAD) && (int'(req.vec_index) < MAX_SIZE);

    // element off the lower triangle or beyond the size in use
    assign bad_idx = (req.col > req.row) || ({1'b0, req.row} >= n_reg)
                     || (int'(req.row) >= MAX_SIZE);

    always_comb
    begin
        tag1_next.valid  = req_valid && (req.command == CMD_UPDATE);
        tag1_next.err    = bad_idx;
        tag1_next.diag   = (req.row == req.col);
        tag1_next.row    = req.row;
        tag1_next.col    = req.col;
        tag1_next.a_real = req.a_real;
        tag1_next.a_imag = req.a_imag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
        end
        else if (adv)
        begin
            tag1_reg <= tag1_next;
        end
    end

    sru_vec_mem u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (VEC_AW'(req.vec_index)),
        .wdata   ({req.x_real, req.x_imag}),
        .re      (adv),
        .raddr_a (VEC_AW'(req.row)),
        .raddr_b (VEC_AW'(req.col)),
        .rdata_a (xi_word),
        .rdata_b (xj_word)
    );

    sru_arith u_arith (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .cfg     (cfg),
        .tag_in  (tag1_reg),
        .xi_word (xi_word),
        .xj_word (xj_word),
        .tag_out (tag5),
        .tr      (tr),
        .ti      (ti)
    );

    // accumulate with saturation, or overwrite; hermitian diagonal forces imag to zero
    always_comb
    begin
        sum_re = (A_W+1)'(tag5.a_real) + (A_W+1)'(tr);
        sum_im = (A_W+1)'(tag5.a_imag) + (A_W+1)'(ti);
        sat_re = sum_re[A_W] != sum_re[A_W-1];
        sat_im = sum_im[A_W] != sum_im[A_W-1];
        val_re = sat_re ? {sum_re[A_W], {(A_W-1){!sum_re[A_W]}}} : sum_re[A_W-1:0];
        val_im = sat_im ? {sum_im[A_W], {(A_W-1){!sum_im[A_W]}}} : sum_im[A_W-1:0];

        rsp_next.out_row = tag5.row;
        rsp_next.out_col = tag5.col;
        if (tag5.err)
        begin
            rsp_next.new_real = tag5.a_real;
            rsp_next.new_imag = tag5.a_imag;
            rsp_next.status   = ST_RANGE;
        end
        else if (accum_reg)
        begin
            rsp_next.new_real = val_re;
            if (herm_reg && tag5.diag)
            begin
                rsp_next.new_imag = '0;
                rsp_next.status   = sat_re ? ST_SAT : ST_OK;
            end
            else
            begin
                rsp_next.new_imag = val_im;
                rsp_next.status   = (sat_re || sat_im) ? ST_SAT : ST_OK;
            end
        end
        else
        begin
            rsp_next.new_real = A_W'(tr);
            rsp_next.new_imag = (herm_reg && tag5.diag) ? '0 : A_W'(ti);
            rsp_next.status   = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rsp_valid_reg <= tag5.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // store is never written while the pipeline is held
    a_we_moves: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> adv)
        else $error("x store written while pipeline stalled");

    // saturation status only comes from the accumulate path
    a_sat_accum: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_SAT) |-> accum_reg)
        else $error("saturation reported in overwrite mode");

    // hermitian diagonal results carry a zero imaginary part
    a_herm_diag: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && herm_reg && rsp.out_row == rsp.out_col && rsp.status != ST_RANGE)
        |-> rsp.new_imag == '0)
        else $error("hermitian diagonal with nonzero imaginary part");

    // a held response leaves the pipeline frozen
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> $stable(tag1_reg))
        else $error("pipeline moved under a stalled response");

endmodule

/* tb/sv/rank1_element_checker.sv */
module rank1_element_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [sru_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [sru_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                         req_valid,
    input  logic                         req_stall,
    input  sru_pkg::req_t                req,
    input  logic                         rsp_valid,
    input  logic                         rsp_stall,
    input  sru_pkg::rsp_t                rsp,
    output int                           mismatches,
    output int                           outstanding,
    output int                           checked,
    output int                           saturated,
    output int                           off_triangle
);
    import sru_pkg::*;

    localparam longint WORD_MAX   = 64'sd2147483647;
    localparam longint WORD_MIN   = -64'sd2147483648;
    localparam longint ROUND_HALF = 64'sd1 <<< (FRAC_SHIFT - 1);

    // shadow of the register file
    logic [N_W-1:0]        size_reg;
    logic signed [X_W-1:0] alpha_re_reg;
    logic signed [X_W-1:0] alpha_im_reg;
    logic                  herm_reg;
    logic                  acc_reg;
    logic                  conj_reg;

    // shadow of the x store
    logic signed [X_W-1:0] x_re_mem [MAX_SIZE];
    logic signed [X_W-1:0] x_im_mem [MAX_SIZE];

    rsp_t expected_elements [$];
    rsp_t want;

    function automatic bit clamp_word(input longint v, output longint w);
        if (v > WORD_MAX)
        begin
            w = WORD_MAX;
            return 1'b1;
        end
        if (v < WORD_MIN)
        begin
            w = WORD_MIN;
            return 1'b1;
        end
        w = v;
        return 1'b0;
    endfunction

    function automatic rsp_t predict_element(input req_t r);
        rsp_t   e;
        longint xri, xii, xrj, xij, pr, pi, alr, ali, tr, ti, ar, ai, nr, ni;
        bit     sat, diag;
        e.out_row  = r.row;
        e.out_col  = r.col;
        e.new_real = r.a_real;
        e.new_imag = r.a_imag;
        e.status   = ST_RANGE;
        if (r.col > r.row || r.row >= size_reg)
            return e;
        xri = $signed(x_re_mem[r.row]);
        xii = $signed(x_im_mem[r.row]);
        xrj = $signed(x_re_mem[r.col]);
        xij = $signed(x_im_mem[r.col]);
        if (conj_reg)
        begin
            xii = -xii;
            xij = -xij;
        end
        if (herm_reg)
            xij = -xij;
        // exact complex product of the two x values
        pr = xri * xrj - xii * xij;
        pi = xri * xij + xii * xrj;
        alr = $signed(alpha_re_reg);
        if (herm_reg)
            ali = 0;
        else
            ali = $signed(alpha_im_reg);
        // scale by alpha, round half up to the element format
        tr = (alr * pr - ali * pi + ROUND_HALF) >>> FRAC_SHIFT;
        ti = (alr * pi + ali * pr + ROUND_HALF) >>> FRAC_SHIFT;
        diag = herm_reg && (r.row == r.col);
        sat = 1'b0;
        ar = $signed(r.a_real);
        ai = $signed(r.a_imag);
        if (acc_reg)
        begin
            sat = clamp_word(ar + tr, nr);
            if (!diag && clamp_word(ai + ti, ni))
                sat = 1'b1;
        end
        else
        begin
            nr = tr;
            ni = ti;
        end
        if (diag)
            ni = 0;
        e.new_real = nr[A_W-1:0];
        e.new_imag = ni[A_W-1:0];
        e.status   = sat ? ST_SAT : ST_OK;
        return e;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg     <= N_W'(64);
            alpha_re_reg <= 16'sd4096;
            alpha_im_reg <= '0;
            herm_reg     <= 1'b0;
            acc_reg      <= 1'b1;
            conj_reg     <= 1'b0;
            expected_elements.delete();
            outstanding  <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_elements.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: response with no update waiting: row %0d col %0d",
                                 $time, rsp.out_row, rsp.out_col);
                end
                else
                begin
                    want = expected_elements.pop_front();
                    checked++;
                    if (want.status == ST_SAT)
                        saturated++;
                    if (want.status == ST_RANGE)
                        off_triangle++;
                    if (rsp.out_row !== want.out_row || rsp.out_col !== want.out_col ||
                        rsp.new_real !== want.new_real || rsp.new_imag !== want.new_imag ||
                        rsp.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display(
                                "%0t: mismatch r/c exp %0d/%0d got %0d/%0d st exp %0d got %0d",
                                $time, want.out_row, want.out_col, rsp.out_row,
                                rsp.out_col, want.status, rsp.status);
                            $display(
                                "    re exp %0d got %0d, im exp %0d got %0d",
                                $signed(want.new_real), $signed(rsp.new_real),
                                $signed(want.new_imag), $signed(rsp.new_imag));
                        end
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                if (req.command == CMD_UPDATE)
                    expected_elements.push_back(predict_element(req));
                else
                begin
                    x_re_mem[req.vec_index] = req.x_real;
                    x_im_mem[req.vec_index] = req.x_imag;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_N:          size_reg     <= cfg_wdata[N_W-1:0];
                    REG_ALPHA_RE:   alpha_re_reg <= cfg_wdata[X_W-1:0];
                    REG_ALPHA_IM:   alpha_im_reg <= cfg_wdata[X_W-1:0];
                    REG_HERMITIAN:  herm_reg     <= cfg_wdata[0];
                    REG_ACCUMULATE: acc_reg      <= cfg_wdata[0];
                    REG_CONJ_X:     conj_reg     <= cfg_wdata[0];
                    default:        ;
                endcase
            end
            outstanding <= expected_elements.size();
        end
    end

endmodule

/* tb/sv/tb_symmetric_rank1_update.sv */
module tb_symmetric_rank1_update;
    import sru_pkg::*;

    localparam int REQ_W = $bits(req_t);

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CIDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]    cfg_wdata;
    logic                req_valid;
    logic                req_stall;
    req_t                req;
    logic                rsp_valid;
    logic                rsp_stall;
    rsp_t                rsp;

    // results from the checker
    int mismatches;
    int outstanding;
    int checked;
    int saturated;
    int off_triangle;

    // stimulus bookkeeping
    bit [MAX_SIZE-1:0] x_loaded;
    int                loaded_list [$];
    int                cur_size;
    int                quiet_left;
    int                loads_sent;
    int                updates_sent;
    int                settings_used;

    symmetric_rank1_update uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    rank1_element_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp          (rsp),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .checked      (checked),
        .saturated    (saturated),
        .off_triangle (off_triangle)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // length of a pause: mostly short, now and then long
    function automatic int pause_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // idle cycles before the next request, with stretches of none at all
    function automatic int idle_gap();
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            quiet_left = $urandom_range(15, 40);
            return 0;
        end
        if ($urandom_range(0, 99) < 55)
            return 0;
        return pause_length();
    endfunction

    // x values, biased toward the format limits
    function automatic logic signed [X_W-1:0] pick_x();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(X_W-1){1'b0}}};
            1:       return {1'b0, {(X_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return X_W'($urandom());
        endcase
    endfunction

    // old element values, biased toward the saturation edges
    function automatic logic signed [A_W-1:0] pick_a();
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(A_W-1){1'b1}}};
            1:       return {1'b1, {(A_W-1){1'b0}}};
            2:       return {1'b0, {(A_W-1){1'b1}}} - $urandom_range(0, 1 << 20);
            3:       return {1'b1, {(A_W-1){1'b0}}} + $urandom_range(0, 1 << 20);
            default: return $urandom();
        endcase
    endfunction

    // unused fields of every request carry random bits
    function automatic req_t make_load(input logic [IDX_W-1:0] idx,
                                       input logic signed [X_W-1:0] xr,
                                       input logic signed [X_W-1:0] xi);
        req_t item;
        item           = REQ_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        item.command   = CMD_LOAD;
        item.vec_index = idx;
        item.x_real    = xr;
        item.x_imag    = xi;
        return item;
    endfunction

    function automatic req_t make_update(input logic [IDX_W-1:0] row_i,
                                         input logic [IDX_W-1:0] col_j,
                                         input logic signed [A_W-1:0] ar,
                                         input logic signed [A_W-1:0] ai);
        req_t item;
        item         = REQ_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        item.command = CMD_UPDATE;
        item.row     = row_i;
        item.col     = col_j;
        item.a_real  = ar;
        item.a_imag  = ai;
        return item;
    endfunction

    function automatic int any_loaded();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    // mostly well-formed updates of loaded x entries, some loads, some off-triangle
    function automatic req_t random_request();
        int rw, cl, lim, tries, tmp;
        lim = (cur_size > MAX_SIZE) ? MAX_SIZE : cur_size;
        if ($urandom_range(0, 99) < 25 || loaded_list.size() == 0)
        begin
            if (lim > 0 && $urandom_range(0, 1) == 1)
                rw = $urandom_range(0, lim - 1);
            else
                rw = $urandom_range(0, MAX_SIZE - 1);
            return make_load(rw[IDX_W-1:0], pick_x(), pick_x());
        end
        rw = any_loaded();
        cl = any_loaded();
        if ($urandom_range(0, 99) < 85)
        begin
            // aim inside the lower triangle of the size in use
            tries = 0;
            while (rw >= lim && tries < 24)
            begin
                rw = any_loaded();
                tries++;
            end
            if ($urandom_range(0, 5) == 0)
                cl = rw;
            else
            begin
                tries = 0;
                while (cl > rw && tries < 24)
                begin
                    cl = any_loaded();
                    tries++;
                end
                if (cl > rw)
                    cl = rw;
            end
        end
        else if (cl < rw)
        begin
            // put the column above the diagonal when the two differ
            tmp = rw;
            rw  = cl;
            cl  = tmp;
        end
        return make_update(rw[IDX_W-1:0], cl[IDX_W-1:0], pick_a(), pick_a());
    endfunction

    // entered and left at a falling edge; valid stays up for a following request
    task automatic send_request(input req_t item);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
        if (item.command == CMD_LOAD)
        begin
            loads_sent++;
            if (!x_loaded[item.vec_index])
            begin
                x_loaded[item.vec_index] = 1'b1;
                loaded_list.push_back(int'(item.vec_index));
            end
        end
        else
            updates_sent++;
    endtask

    // block drained and quiet: no update in flight, loads settled
    task automatic settle();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
    endtask

    // every register gets written for each new setting
    task automatic program_settings(input logic [N_W-1:0] size,
                                    input logic signed [X_W-1:0] are,
                                    input logic signed [X_W-1:0] aim,
                                    input logic herm,
                                    input logic acc,
                                    input logic conj);
        write_reg(REG_N, CFG_W'(size));
        write_reg(REG_ALPHA_RE, are);
        write_reg(REG_ALPHA_IM, aim);
        write_reg(REG_HERMITIAN, CFG_W'(herm));
        write_reg(REG_ACCUMULATE, CFG_W'(acc));
        write_reg(REG_CONJ_X, CFG_W'(conj));
        cfg_we   <= 1'b0;
        cur_size = size;
        settings_used++;
    endtask

    task automatic run_random(input int count);
        int k;
        for (k = 0; k < count; k++)
        begin
            if (k == count / 2)
            begin
                // hold off until every outstanding update has come back
                req_valid <= 1'b0;
                do
                    @(negedge clk);
                while (outstanding != 0);
            end
            send_request(random_request());
        end
    endtask

    // response side: random stalls, free-running stretches in between
    initial
    begin
        int  run;
        int  r;
        bit  level;
        rsp_stall = 1'b0;
        run = 0;
        level = 1'b0;
        forever
        begin
            @(negedge clk);
            if (run == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                begin
                    level = 1'b0;
                    run = $urandom_range(30, 120);
                end
                else if (r < 50)
                begin
                    level = 1'b1;
                    run = pause_length();
                end
                else
                begin
                    level = 1'b0;
                    run = $urandom_range(1, 6);
                end
            end
            rsp_stall <= level;
            run--;
        end
    end

    initial
    begin
        int ph;
        logic [N_W-1:0] size;
        req_valid     = 1'b0;
        req           = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        rst_n         = 1'b0;
        x_loaded      = '0;
        cur_size      = MAX_SIZE;
        quiet_left    = 0;
        loads_sent    = 0;
        updates_sent  = 0;
        settings_used = 1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part under the reset settings: x at the format limits
        send_request(make_load(6'd0, 16'sh7fff, 16'sh8000));
        send_request(make_load(6'd63, 16'sh8000, 16'sh7fff));
        send_request(make_load(6'd1, 16'sh8000, 16'sh8000));
        send_request(make_load(6'd2, 16'sh0000, 16'sh0000));
        send_request(make_load(6'd42, 16'shffff, 16'sh0001));
        // old values at both limits on the first diagonal element
        send_request(make_update(6'd0, 6'd0, 32'sh7fffffff, 32'sh7fffffff));
        send_request(make_update(6'd0, 6'd0, 32'sh80000000, 32'sh80000000));
        send_request(make_update(6'd63, 6'd0, 32'sh80000000, 32'sh7fffffff));
        send_request(make_update(6'd63, 6'd63, 32'sh00000000, 32'sh00000000));
        send_request(make_update(6'd1, 6'd1, 32'sh7fff0000, 32'shffffffff));
        send_request(make_update(6'd2, 6'd0, 32'sh00000000, 32'sh00000000));
        // column above the diagonal passes through flagged
        send_request(make_update(6'd0, 6'd1, 32'sd123, -32'sd456));
        send_request(make_update(6'd63, 6'd42, pick_a(), pick_a()));
        send_request(make_update(6'd42, 6'd2, pick_a(), pick_a()));
        // reload then use it on the very next request
        send_request(make_load(6'd63, 16'sh7fff, 16'sh7fff));
        send_request(make_update(6'd63, 6'd63, 32'sh7ff00000, 32'sh80100000));
        send_request(make_update(6'd63, 6'd1, pick_a(), pick_a()));

        // zero size: every update off the triangle
        settle();
        program_settings(7'd0, 16'sd4096, 16'sd0, 1'b0, 1'b1, 1'b0);
        run_random(12);

        // size above the store, alpha at its limits, conjugated x
        settle();
        program_settings(7'd127, 16'sh7fff, 16'sh8000, 1'b0, 1'b1, 1'b1);
        run_random(60);

        // single element, hermitian overwrite
        settle();
        program_settings(7'd1, 16'sh8000, 16'sh7fff, 1'b1, 1'b0, 1'b0);
        run_random(40);

        // hermitian accumulate on the full size with conjugated x
        settle();
        program_settings(7'd64, pick_x(), pick_x(), 1'b1, 1'b1, 1'b1);
        run_random(70);

        // random settings, extremes of the size mixed in
        for (ph = 0; ph < 6; ph++)
        begin
            case ($urandom_range(0, 5))
                0:       size = 7'd1;
                1:       size = 7'd64;
                2:       size = N_W'($urandom_range(65, 127));
                default: size = N_W'($urandom_range(2, 63));
            endcase
            settle();
            program_settings(size, pick_x(), pick_x(), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            run_random(60);
        end

        // drain, then allow for the pipeline depth
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (12) @(negedge clk);

        $display("covered %0d x loads and %0d element updates over %0d register settings",
                 loads_sent, updates_sent, settings_used);
        $display("compared %0d responses, %0d saturated and %0d off the triangle",
                 checked, saturated, off_triangle);
        if (mismatches == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* symmetric_rank1_update.f */
sv/sru_pkg.sv
sv/sru_vec_mem.sv
sv/sru_arith.sv
sv/symmetric_rank1_update.sv
tb/sv/rank1_element_checker.sv
tb/sv/tb_symmetric_rank1_update.sv
